/* sv/p2f_pkg.sv */
// Shared types and codes for the packet-to-flit segmenter.
package p2f_pkg;

    typedef struct packed {
        logic [2:0] dst_clu;
        logic [2:0] src_clu;
        logic [3:0] dst_hub;
        logic [3:0] src_hub;
        logic [5:0] dst_node;
        logic [5:0] src_node;
    } t_hdr;

    localparam int HDR_W  = $bits(t_hdr);
    localparam int TIME_W = 32;
    localparam int SEQ_W  = 6;
    localparam int LEN_W  = 7;

    localparam logic [1:0] KIND_HEAD = 2'd0;
    localparam logic [1:0] KIND_BODY = 2'd1;
    localparam logic [1:0] KIND_TAIL = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

/* sv/p2f_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module p2f_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 8
    )
    (
        input  logic                     i_clk,
        input  logic                     i_wr_en,
        input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
        input  logic [WIDTH-1:0]         i_wr_data,
        input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
        output logic [WIDTH-1:0]         o_rd_data
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/p2f_queue.sv */
// Packet queue: RAM storage, pointers, fill count and front-entry bypass.
module p2f_queue
    import p2f_pkg::*;
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 8
    )
    (
        input  logic             i_clk,
        input  logic             i_rst_n,
        input  t_q_cmd           i_cmd,
        input  logic [WIDTH-1:0] i_push_data,
        output logic [WIDTH-1:0] o_front,
        output t_q_stat          o_stat
    );

    localparam int AW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [AW-1:0]    r_rd_ptr;
    logic [AW-1:0]    r_wr_ptr;
    logic [CNTW-1:0]  r_count;
    logic             r_byp;
    logic [WIDTH-1:0] r_byp_data;

    logic [AW-1:0]    n_rd_ptr;
    logic [AW-1:0]    n_wr_ptr;
    logic [CNTW-1:0]  n_count;
    logic [WIDTH-1:0] ram_q;
    logic [WIDTH-1:0] stored_front;

    assign n_rd_ptr = !i_cmd.pop ? r_rd_ptr :
                      (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign n_wr_ptr = !i_cmd.push ? r_wr_ptr :
                      (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_count  = r_count + CNTW'(i_cmd.push) - CNTW'(i_cmd.pop);

    p2f_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (i_push_data),
        .i_rd_addr (n_rd_ptr),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
            r_byp    <= 1'b0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            r_byp    <= i_cmd.push && (r_wr_ptr == n_rd_ptr);
        end
        r_byp_data <= i_push_data;
    end

    assign stored_front = r_byp ? r_byp_data : ram_q;
    assign o_front      = (r_count == '0) ? i_push_data : stored_front;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNTW'(DEPTH));

endmodule

/* sv/packet_to_flit_segmenter_top.sv */
// Packet-to-flit segmenter: input register, flit step logic and result register.
// Each taken beat is held in the input register, then its result is held in the result register.
// Throughput: one beat per cycle, limited only by the output stall.
// Each input beat yields exactly one result beat, flit or not.
// Synchronous active-low reset empties the queue, clears the flit counter
// and the request toggle; the request level output and queue RAM contents are not cleared.
module packet_to_flit_segmenter_top
    import p2f_pkg::*;
    #(
        parameter int QUEUE_DEPTH      = 8,
        parameter int MAX_PACKET_FLITS = 64
    )
    (
        input  logic              i_clk,
        input  logic              i_rst_n,
        input  logic              i_valid,
        output logic              o_stall,
        input  logic              i_packet_valid,
        input  logic [5:0]        i_pkt_src_node,
        input  logic [5:0]        i_pkt_dst_node,
        input  logic [3:0]        i_pkt_src_hub,
        input  logic [3:0]        i_pkt_dst_hub,
        input  logic [2:0]        i_pkt_src_cluster,
        input  logic [2:0]        i_pkt_dst_cluster,
        input  logic [TIME_W-1:0] i_pkt_time,
        input  logic [LEN_W-1:0]  i_pkt_length,
        input  logic              i_ack_level,
        output logic              o_valid,
        input  logic              i_stall,
        output logic              o_flit_valid,
        output logic [5:0]        o_flit_src_node,
        output logic [5:0]        o_flit_dst_node,
        output logic [3:0]        o_flit_src_hub,
        output logic [3:0]        o_flit_dst_hub,
        output logic [2:0]        o_flit_src_cluster,
        output logic [2:0]        o_flit_dst_cluster,
        output logic [TIME_W-1:0] o_flit_time,
        output logic [SEQ_W-1:0]  o_flit_sequence,
        output logic [1:0]        o_flit_kind,
        output logic              o_request_level,
        output logic              o_packet_dropped
    );

    localparam int LW = $clog2(MAX_PACKET_FLITS + 1);
    localparam int CW = (LW > LEN_W) ? LW : LEN_W;
    localparam int SW = (LW > SEQ_W) ? LW : SEQ_W;
    localparam int EW = TIME_W + LW + HDR_W;

    // input register
    logic              r_in_valid;
    logic              r_pkt_valid;
    t_hdr              r_pkt_hdr;
    logic [TIME_W-1:0] r_pkt_time;
    logic [LEN_W-1:0]  r_pkt_length;
    logic              r_ack;

    // step state
    logic              r_tx;
    logic [LW-1:0]     r_left;

    // result register
    logic              r_out_valid;
    logic              r_flit_valid;
    t_hdr              r_flit_hdr;
    logic [TIME_W-1:0] r_flit_time;
    logic [SEQ_W-1:0]  r_flit_seq;
    logic [1:0]        r_flit_kind;
    logic              r_req;
    logic              r_dropped;

    logic              advance;
    logic              step;
    logic [CW-1:0]     len_ext;
    logic [LW-1:0]     len_sat;
    t_q_cmd            q_cmd;
    t_q_stat           q_stat;
    logic [EW-1:0]     push_data;
    logic [EW-1:0]     front;
    t_hdr              f_hdr;
    logic [LW-1:0]     f_len;
    logic [TIME_W-1:0] f_time;
    logic              push_ok;
    logic              go;
    logic              send;
    logic [LW-1:0]     eff_left;
    logic [LW-1:0]     left_dec;
    logic [SW-1:0]     seq_w;
    logic [1:0]        kind;
    logic [LW-1:0]     n_left;
    logic              n_tx;

    assign advance = !r_out_valid || !i_stall;
    assign step    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall) begin
            r_pkt_valid        <= i_packet_valid;
            r_pkt_hdr.src_node <= i_pkt_src_node;
            r_pkt_hdr.dst_node <= i_pkt_dst_node;
            r_pkt_hdr.src_hub  <= i_pkt_src_hub;
            r_pkt_hdr.dst_hub  <= i_pkt_dst_hub;
            r_pkt_hdr.src_clu  <= i_pkt_src_cluster;
            r_pkt_hdr.dst_clu  <= i_pkt_dst_cluster;
            r_pkt_time         <= i_pkt_time;
            r_pkt_length       <= i_pkt_length;
            r_ack              <= i_ack_level;
        end
    end

    // clamp length to 1..MAX_PACKET_FLITS
    always_comb begin
        len_ext = CW'(r_pkt_length);
        if (len_ext == '0) begin
            len_ext = CW'(1);
        end
        if (len_ext > CW'(MAX_PACKET_FLITS)) begin
            len_ext = CW'(MAX_PACKET_FLITS);
        end
        len_sat = len_ext[LW-1:0];
    end

    assign push_data = {r_pkt_time, len_sat, r_pkt_hdr};
    assign push_ok   = r_pkt_valid && !q_stat.full;

    p2f_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_push_data (push_data),
        .o_front     (front),
        .o_stat      (q_stat)
    );

    assign f_hdr  = t_hdr'(front[HDR_W-1:0]);
    assign f_len  = front[HDR_W +: LW];
    assign f_time = front[EW-1 -: TIME_W];

    always_comb begin
        go       = (r_ack == r_tx) && (push_ok || !q_stat.empty);
        eff_left = ((r_left == '0) || (r_left > f_len)) ? f_len : r_left;
        left_dec = eff_left - 1'b1;
        seq_w    = SW'(f_len) - SW'(eff_left);
        if (eff_left == f_len) begin
            kind = KIND_HEAD;
        end else if (eff_left == LW'(1)) begin
            kind = KIND_TAIL;
        end else begin
            kind = KIND_BODY;
        end
        send   = go && (f_time != '0);
        n_left = go ? left_dec : r_left;
        n_tx   = r_tx ^ send;
        q_cmd.push = step && push_ok;
        q_cmd.pop  = step && go && (left_dec == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx        <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_tx   <= n_tx;
                r_left <= n_left;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (step) begin
            r_flit_valid <= send;
            r_flit_hdr   <= send ? f_hdr : '0;
            r_flit_time  <= send ? f_time : '0;
            r_flit_seq   <= send ? seq_w[SEQ_W-1:0] : '0;
            r_flit_kind  <= send ? kind : KIND_HEAD;
            r_req        <= n_tx;
            r_dropped    <= r_pkt_valid && q_stat.full;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_flit_valid       = r_flit_valid;
    assign o_flit_src_node    = r_flit_hdr.src_node;
    assign o_flit_dst_node    = r_flit_hdr.dst_node;
    assign o_flit_src_hub     = r_flit_hdr.src_hub;
    assign o_flit_dst_hub     = r_flit_hdr.dst_hub;
    assign o_flit_src_cluster = r_flit_hdr.src_clu;
    assign o_flit_dst_cluster = r_flit_hdr.dst_clu;
    assign o_flit_time        = r_flit_time;
    assign o_flit_sequence    = r_flit_seq;
    assign o_flit_kind        = r_flit_kind;
    assign o_request_level    = r_req;
    assign o_packet_dropped   = r_dropped;

endmodule
